// ----- sv/atsf_pkg.sv -----
// shared types, constants and the arctangent table of the tilt smoothing filter
package atsf_pkg;

  // field widths
  localparam int ACCEL_W  = 16;
  localparam int OUT_W    = 16;
  localparam int WEIGHT_W = 16;
  localparam int ANGLE_W  = 32;  // Q3.28 radians
  localparam int PROD_W   = 50;  // 18 x 32 signed product
  localparam int SQ_W     = 32;  // ay^2 + az^2
  localparam int RAD_W    = 48;  // radicand (ay^2 + az^2) << 16
  localparam int MAG_W    = 24;  // square root of the radicand
  localparam int CORDIC_W = 28;  // cordic x and y
  localparam int Z_W      = 34;  // cordic angle accumulator, 2^-30 rad units

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd64225;

  // cordic and square root iteration limits
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int SQRT_STEPS       = 24;
  localparam int STEP_IW          = 5;

  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] PI_Q28 = 34'sd843314857;
  localparam int PI_Q13 = 25736;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_YY,
    DP_MUL_ZZ,
    DP_SQ_SUM,
    DP_SQRT_STEP,
    DP_COR_INIT_P,
    DP_COR_INIT_R,
    DP_COR_STEP,
    DP_FILT_MUL_P,
    DP_FILT_UPD_P,
    DP_FILT_MUL_R,
    DP_FILT_UPD_R,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    logic [STEP_IW-1:0] idx;
  } atsf_cmd_t;

  // arctangent of 2^-i in 2^-30 rad units, truncated
  function automatic logic [29:0] atan_lut(input logic [STEP_IW-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/atsf_in_if.sv -----
// input channel carrying one accelerometer sample per transfer
interface atsf_in_if import atsf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_x;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// ----- sv/atsf_out_if.sv -----
// output channel carrying filtered pitch and roll per transfer
interface atsf_out_if import atsf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pitch_angle;
  logic signed [OUT_W-1:0] roll_angle;

  modport source (output valid, output pitch_angle, output roll_angle, input ready);
  modport sink   (input valid, input pitch_angle, input roll_angle, output ready);
endinterface

// ----- sv/atsf_ctrl.sv -----
// sequencing state machine of the tilt smoothing filter
module atsf_ctrl import atsf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output atsf_cmd_t cmd_o
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  typedef enum logic [3:0] {
    S_IDLE, S_SQY, S_SQZ, S_SQSUM, S_SQRT, S_PINIT, S_PSTEP,
    S_RINIT, S_RSTEP, S_FMP, S_FUP, S_FMR, S_FUR, S_OUT
  } state_e;

  state_e             state_q;
  logic [STEP_IW-1:0] cnt_q;
  logic               out_valid_q;
  logic               out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o.idx = cnt_q;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? DP_LOAD : DP_NOP;
      S_SQY:   cmd_o.op = DP_MUL_YY;
      S_SQZ:   cmd_o.op = DP_MUL_ZZ;
      S_SQSUM: cmd_o.op = DP_SQ_SUM;
      S_SQRT:  cmd_o.op = DP_SQRT_STEP;
      S_PINIT: cmd_o.op = DP_COR_INIT_P;
      S_PSTEP: cmd_o.op = DP_COR_STEP;
      S_RINIT: cmd_o.op = DP_COR_INIT_R;
      S_RSTEP: cmd_o.op = DP_COR_STEP;
      S_FMP:   cmd_o.op = DP_FILT_MUL_P;
      S_FUP:   cmd_o.op = DP_FILT_UPD_P;
      S_FMR:   cmd_o.op = DP_FILT_MUL_R;
      S_FUR:   cmd_o.op = DP_FILT_UPD_R;
      S_OUT:   cmd_o.op = out_free ? DP_OUT_LOAD : DP_NOP;
      default: cmd_o.op = DP_NOP;
    endcase
  end

  // state, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SQY;
        end
        S_SQY:   state_q <= S_SQZ;
        S_SQZ:   state_q <= S_SQSUM;
        S_SQSUM: begin
          state_q <= S_SQRT;
          cnt_q   <= '0;
        end
        S_SQRT: begin
          if (cnt_q == STEP_IW'(SQRT_STEPS - 1)) begin
            state_q <= S_PINIT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_PINIT: state_q <= S_PSTEP;
        S_PSTEP: begin
          if (cnt_q == STEP_IW'(NSTEP - 1)) begin
            state_q <= S_RINIT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RINIT: state_q <= S_RSTEP;
        S_RSTEP: begin
          if (cnt_q == STEP_IW'(NSTEP - 1)) begin
            state_q <= S_FMP;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FMP: state_q <= S_FUP;
        S_FUP: state_q <= S_FMR;
        S_FMR: state_q <= S_FUR;
        S_FUR: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/atsf_dp.sv -----
// datapath: squares, bit-serial square root, shared cordic, filter and output register
module atsf_dp import atsf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  atsf_cmd_t                  cmd_i,
  input  logic                       cfg_we_i,
  input  logic [WEIGHT_W-1:0]        cfg_wdata_i,
  input  logic signed [ACCEL_W-1:0]  accel_x_i,
  input  logic signed [ACCEL_W-1:0]  accel_y_i,
  input  logic signed [ACCEL_W-1:0]  accel_z_i,
  output logic signed [OUT_W-1:0]    pitch_angle_o,
  output logic signed [OUT_W-1:0]    roll_angle_o
);

  // sample and intermediate registers
  logic signed [ACCEL_W-1:0]  ax_q, ay_q, az_q;
  logic                       zero_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [SQ_W-1:0]            sq_q;
  logic [RAD_W-1:0]           v_q, r_q, b_q;
  logic signed [CORDIC_W-1:0] cx_q, cy_q;
  logic signed [Z_W-1:0]      cz_q;
  logic signed [ANGLE_W-1:0]  ap_q, ar_q;
  logic signed [ANGLE_W-1:0]  sp_q, sr_q;
  logic [WEIGHT_W-1:0]        weight_q;
  logic signed [OUT_W-1:0]    pitch_q, roll_q;

  // rounding and clamping of the cordic angle to Q3.28
  function automatic logic signed [ANGLE_W-1:0] z_to_q28(input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] t;
    t = (z + 34'sd2) >>> 2;
    if (t > PI_Q28) t = PI_Q28;
    else if (t < -PI_Q28) t = -PI_Q28;
    return t[ANGLE_W-1:0];
  endfunction

  // rounding and clamping of the filter state to Q2.13
  function automatic logic signed [OUT_W-1:0] to_q13(input logic signed [ANGLE_W-1:0] s);
    logic signed [ANGLE_W:0] t;
    t = ((ANGLE_W+1)'(s) + 33'sd16384) >>> 15;
    if (t > 33'(PI_Q13)) t = 33'(PI_Q13);
    else if (t < -33'(PI_Q13)) t = -33'(PI_Q13);
    return t[OUT_W-1:0];
  endfunction

  // shared multiplier operands
  logic signed [17:0]         ma;
  logic signed [ANGLE_W-1:0]  mb;
  always_comb begin
    unique case (cmd_i.op)
      DP_MUL_YY: begin
        ma = 18'(ay_q);
        mb = 32'(ay_q);
      end
      DP_MUL_ZZ: begin
        ma = 18'(az_q);
        mb = 32'(az_q);
      end
      DP_FILT_MUL_P: begin
        ma = signed'({2'b00, weight_q});
        mb = sp_q - ap_q;
      end
      DP_FILT_MUL_R: begin
        ma = signed'({2'b00, weight_q});
        mb = sr_q - ar_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // square root step
  logic [RAD_W:0] rb;
  logic           sqrt_ge;
  assign rb      = {1'b0, r_q} + {1'b0, b_q};
  assign sqrt_ge = ({1'b0, v_q} >= rb);

  // cordic start vector selection
  logic signed [CORDIC_W-1:0] x_in, y_in;
  always_comb begin
    if (cmd_i.op == DP_COR_INIT_P) begin
      x_in = signed'({{(CORDIC_W-MAG_W){1'b0}}, r_q[MAG_W-1:0]});
      y_in = (-CORDIC_W'(ax_q)) <<< 8;
    end else begin
      x_in = CORDIC_W'(az_q) <<< 8;
      y_in = CORDIC_W'(ay_q) <<< 8;
    end
  end

  // cordic micro-rotation
  logic signed [CORDIC_W-1:0] dx, dy;
  logic signed [Z_W-1:0]      at;
  assign dx = cy_q >>> cmd_i.idx;
  assign dy = cx_q >>> cmd_i.idx;
  assign at = signed'({4'b0000, atan_lut(cmd_i.idx)});

  // filter update sum
  logic signed [PROD_W-1:0] acc_p, acc_r;
  assign acc_p = (PROD_W'(ap_q) <<< 16) + prod_q + 50'sd32768;
  assign acc_r = (PROD_W'(ar_q) <<< 16) + prod_q + 50'sd32768;

  logic signed [ANGLE_W-1:0] z_angle;
  assign z_angle = zero_q ? '0 : z_to_q28(cz_q);

  // weight register and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
      sp_q     <= '0;
      sr_q     <= '0;
    end else begin
      if (cfg_we_i) weight_q <= cfg_wdata_i;
      if (cmd_i.op == DP_FILT_UPD_P) sp_q <= acc_p[ANGLE_W+15:16];
      if (cmd_i.op == DP_FILT_UPD_R) sr_q <= acc_r[ANGLE_W+15:16];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    unique case (cmd_i.op)
      DP_LOAD: begin
        ax_q   <= accel_x_i;
        ay_q   <= accel_y_i;
        az_q   <= accel_z_i;
        zero_q <= (accel_y_i == '0) && (accel_z_i == '0);
      end
      DP_MUL_ZZ: sq_q <= prod_q[SQ_W-1:0];
      DP_SQ_SUM: begin
        v_q <= {SQ_W'(sq_q + prod_q[SQ_W-1:0]), 16'h0000};
        r_q <= '0;
        b_q <= RAD_W'(1) << 46;
      end
      DP_SQRT_STEP: begin
        if (sqrt_ge) begin
          v_q <= v_q - rb[RAD_W-1:0];
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      DP_COR_INIT_P, DP_COR_INIT_R: begin
        if (cmd_i.op == DP_COR_INIT_R) ap_q <= z_angle;
        if (x_in < 0) begin
          cx_q <= -x_in;
          cy_q <= -y_in;
          cz_q <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
          cx_q <= x_in;
          cy_q <= y_in;
          cz_q <= '0;
        end
      end
      DP_COR_STEP: begin
        if (cy_q >= 0) begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + at;
        end else begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - at;
        end
      end
      DP_FILT_MUL_P: ar_q <= z_angle;
      DP_OUT_LOAD: begin
        pitch_q <= to_q13(sp_q);
        roll_q  <= to_q13(sr_q);
      end
      default: ;
    endcase
  end

  assign pitch_angle_o = pitch_q;
  assign roll_angle_o  = roll_q;

endmodule

// ----- sv/accel_tilt_smoothing_filter_top.sv -----
// samples are taken one at a time: the next is taken only once the last has reached the output
// register; the pace is set by the 24-step square root and the one cordic unit shared by
// pitch and roll
// the output register holds a result while the next sample is taken and worked on
// reset: controller idle, filter states zero, smoothing weight 64225
module accel_tilt_smoothing_filter_top import atsf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  atsf_in_if.sink             in_i,
  atsf_out_if.source          out_o
);

  atsf_cmd_t cmd;

  // sequencer
  atsf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // arithmetic
  atsf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accel_x_i     (in_i.accel_x),
    .accel_y_i     (in_i.accel_y),
    .accel_z_i     (in_i.accel_z),
    .pitch_angle_o (out_o.pitch_angle),
    .roll_angle_o  (out_o.roll_angle)
  );

endmodule

// ----- sv/atsf_checker.sv -----
// port-level checks of the tilt smoothing filter and their binding
module atsf_port_checker import atsf_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [OUT_W-1:0] pitch_i,
  input logic signed [OUT_W-1:0] roll_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(pitch_i) && $stable(roll_i))
    else $error("result payload changed while stalled");

  // one sample in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second sample taken while busy");

  // angles stay within plus or minus pi
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pitch_i <= 16'sd25736) && (pitch_i >= -16'sd25736) &&
                    (roll_i <= 16'sd25736) && (roll_i >= -16'sd25736))
    else $error("angle outside plus or minus pi");

endmodule

bind accel_tilt_smoothing_filter_top atsf_port_checker u_atsf_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pitch_i     (out_o.pitch_angle),
  .roll_i      (out_o.roll_angle)
);

// ----- dv/atsf_checker.sv -----
// checker for the tilt smoothing filter: watches both channels, predicts and compares
module atsf_checker import atsf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WEIGHT_W-1:0] cfg_wdata_i,
  atsf_in_if                  sample_i,
  atsf_out_if                 tilt_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_MAX = 20;

  typedef struct packed {
    logic signed [OUT_W-1:0] pitch;
    logic signed [OUT_W-1:0] roll;
  } tilt_t;

  // arctangent of 2^-i in 2^-30 rad, truncated
  longint atan_step [ATAN_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  logic [WEIGHT_W-1:0]       weight;
  logic signed [ANGLE_W-1:0] pitch_state;
  logic signed [ANGLE_W-1:0] roll_state;
  tilt_t                     tilt_q [$];

  function automatic longint limit(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // bitwise integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 46;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // cordic vectoring atan2(y, x), returned as Q3.28 clamped to +-pi
  function automatic longint vector_angle(input longint y, input longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    // left half plane: turn by 180 degrees first
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += atan_step[i];
      end else begin
        x -= dx;
        y += dy;
        z -= atan_step[i];
      end
    end
    return limit((z + 2) >>> 2, longint'(PI_Q28));
  endfunction

  // exponential smoothing with round half up
  function automatic longint blend(input longint prev, input longint angle, input longint w);
    longint acc;
    acc = w * prev + (65536 - w) * angle + 32768;
    return limit(acc >>> 16, longint'(PI_Q28));
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input longint s);
    return OUT_W'(limit((s + 16384) >>> 15, longint'(PI_Q13)));
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_cnt_o < PRINT_MAX) $display("[%0t] tilt check: %s", $time, msg);
    fail_cnt_o++;
  endtask

  // one sample in: update both filter states and queue the expected angles
  task automatic advance_filter(input longint ax, input longint ay, input longint az);
    longint          pitch;
    longint          roll;
    longint unsigned radicand;
    tilt_t           t;
    pitch = 0;
    roll  = 0;
    if (ay != 0 || az != 0) begin
      radicand = longint'(ay * ay + az * az) << 16;
      pitch    = vector_angle(-ax * 256, longint'(root_floor(radicand)));
      roll     = vector_angle(ay * 256, az * 256);
    end
    pitch_state = ANGLE_W'(blend(pitch_state, pitch, longint'(weight)));
    roll_state  = ANGLE_W'(blend(roll_state, roll, longint'(weight)));
    t.pitch = to_out(pitch_state);
    t.roll  = to_out(roll_state);
    tilt_q.push_back(t);
  endtask

  // sample config writes and transfers on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    tilt_t want;
    if (!rst_ni) begin
      weight      = WEIGHT_RESET;
      pitch_state = '0;
      roll_state  = '0;
      tilt_q.delete();
      fail_cnt_o  = 0;
      checked_o   = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) weight = cfg_wdata_i;
      if (sample_i.valid && sample_i.ready) begin
        advance_filter(longint'(sample_i.accel_x), longint'(sample_i.accel_y),
                       longint'(sample_i.accel_z));
      end
      if (tilt_i.valid && tilt_i.ready) begin
        checked_o++;
        if (tilt_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", checked_o));
        end else begin
          want = tilt_q.pop_front();
          if (tilt_i.pitch_angle !== want.pitch)
            report_mismatch($sformatf("result %0d pitch got %0d want %0d", checked_o,
                                      tilt_i.pitch_angle, want.pitch));
          if (tilt_i.roll_angle !== want.roll)
            report_mismatch($sformatf("result %0d roll got %0d want %0d", checked_o,
                                      tilt_i.roll_angle, want.roll));
        end
      end
      pending_o = tilt_q.size();
    end
  end

endmodule

// ----- dv/tb_accel_tilt_smoothing_filter_top.sv -----
// testbench top for the tilt smoothing filter: clock, reset, stimulus and verdict
module tb_accel_tilt_smoothing_filter_top import atsf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 5;
  localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } accel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [WEIGHT_W-1:0] cfg_wdata;
  bit                  idle_free;
  accel_t              last_sample;
  int                  sent_cnt;
  int                  weight_cnt;
  int                  cycle_cnt = 0;
  int                  fail_cnt;
  int                  pending;
  int                  checked;

  atsf_in_if  sample_ch ();
  atsf_out_if tilt_ch ();

  accel_tilt_smoothing_filter_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (sample_ch),
    .out_o      (tilt_ch)
  );

  atsf_checker #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_ch),
    .tilt_i     (tilt_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // clock
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
      $display("accel_tilt_smoothing_filter_top verification failed");
      $finish;
    end
  end

  function automatic logic signed [ACCEL_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // mix of full-range, drifting, gentle, axis-zero and corner samples
  function automatic accel_t draw_sample();
    accel_t s;
    int     kind;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      s.x = 16'($urandom);
      s.y = 16'($urandom);
      s.z = 16'($urandom);
    end else if (kind < 60) begin
      s.x = last_sample.x + 16'($urandom_range(0, 512)) - 16'sd256;
      s.y = last_sample.y + 16'($urandom_range(0, 512)) - 16'sd256;
      s.z = last_sample.z + 16'($urandom_range(0, 512)) - 16'sd256;
    end else if (kind < 75) begin
      s.x = 16'($urandom_range(0, 4095)) - 16'sd2048;
      s.y = 16'($urandom_range(0, 4095)) - 16'sd2048;
      s.z = 16'($urandom_range(0, 4095)) + 16'sd14336;
    end else if (kind < 88) begin
      s.x = 16'($urandom);
      s.y = ($urandom_range(0, 2) != 0) ? 16'sd0 : 16'($urandom);
      s.z = ($urandom_range(0, 2) != 1) ? 16'sd0 : 16'($urandom);
    end else begin
      s.x = corner_value();
      s.y = corner_value();
      s.z = corner_value();
    end
    return s;
  endfunction

  // present one sample and hold it until the transfer; called just after a rising edge
  task automatic send_sample(input accel_t s);
    int gap;
    bit took;
    gap = idle_free ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_x <= s.x;
    sample_ch.accel_y <= s.y;
    sample_ch.accel_z <= s.z;
    do begin
      @(negedge clk_i);
      took = sample_ch.ready;
      @(posedge clk_i);
    end while (!took);
    last_sample = s;
    sent_cnt++;
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    accel_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    send_sample(s);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      // occasional stretches with no idling on either side
      if (i % 40 == 0) idle_free = ($urandom_range(0, 3) == 0);
      send_sample(draw_sample());
    end
    idle_free = 1'b0;
  endtask

  // weight writes only once every pending result has been taken
  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    sample_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    weight_cnt++;
  endtask

  // corner samples and special angles
  task automatic run_directed();
    send_xyz(0, 0, 0);                  // ay and az both zero
    send_xyz(32767, 0, 0);
    send_xyz(-32768, 0, 0);
    send_xyz(0, 0, 16384);              // y starts at zero, roll stays zero
    send_xyz(0, 0, -1);                 // negative z, zero y: roll starts at +pi
    send_xyz(0, -1, -32768);            // third quadrant: roll starts at -pi
    send_xyz(0, 1, -32768);
    send_xyz(-32768, 1, 0);             // pitch near +pi/2
    send_xyz(32767, -1, 0);             // pitch near -pi/2
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(-32768, -32768, 32767);
    send_xyz(12, -32768, 0);
    send_xyz(0, 32767, -32768);
    send_xyz(1, 1, 1);
    send_xyz(-1, -1, -1);
  endtask

  // result side: random stalls of ready between transfers
  initial begin
    int gap;
    bit got;
    tilt_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = idle_free ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        tilt_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tilt_ch.ready <= 1'b1;
      do begin
        @(negedge clk_i);
        got = tilt_ch.valid;
        @(posedge clk_i);
      end while (!got);
    end
  end

  // reset, stimulus phases and verdict
  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.accel_x <= '0;
    sample_ch.accel_y <= '0;
    sample_ch.accel_z <= '0;
    idle_free   = 1'b0;
    last_sample = '0;
    sent_cnt    = 0;
    weight_cnt  = 1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_random(200);
    set_weight(16'd0);
    run_directed();
    run_random(190);
    set_weight(16'hFFFF);
    run_random(200);
    set_weight(16'd1);
    run_random(150);
    set_weight(16'd32768);
    run_random(200);
    repeat (2) begin
      set_weight(16'($urandom));
      run_random(200);
    end
    set_weight(WEIGHT_RESET);
    run_random(200);

    sample_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d samples under %0d smoothing weights, 0 and 65535 included",
             sent_cnt, weight_cnt);
    $display("%0d filtered results compared, %0d mismatches", checked, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("accel_tilt_smoothing_filter_top verification clean");
    end else begin
      $display("accel_tilt_smoothing_filter_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/atsf_pkg.sv
sv/atsf_in_if.sv
sv/atsf_out_if.sv
sv/atsf_ctrl.sv
sv/atsf_dp.sv
sv/accel_tilt_smoothing_filter_top.sv
sv/atsf_checker.sv
dv/atsf_checker.sv
dv/tb_accel_tilt_smoothing_filter_top.sv
